### rtl/kea_pkg.sv
// Package: shared types and constants for the key event autorelease block.
package kea_pkg;

   // Field widths
   localparam int CodeBits  = 9;
   localparam int TickBits  = 17;
   localparam int LimitBits = 16;
   localparam int CsrIdxBits = 2;
   localparam int CsrDataBits = 16;

   // Command codes
   localparam logic CmdKey  = 1'b0;
   localparam logic CmdTick = 1'b1;

   // Configuration register indexes
   localparam logic [CsrIdxBits-1:0] RegKeyRelease   = 2'd0;
   localparam logic [CsrIdxBits-1:0] RegShiftRelease = 2'd1;
   localparam logic [CsrIdxBits-1:0] RegSourceRel    = 2'd2;

   // Character ranges
   localparam logic [CodeBits-1:0] CharUpperA = CodeBits'(65);
   localparam logic [CodeBits-1:0] CharUpperZ = CodeBits'(90);
   localparam logic [CodeBits-1:0] CharLowerA = CodeBits'(97);
   localparam logic [CodeBits-1:0] CharLowerZ = CodeBits'(122);
   localparam logic [CodeBits-1:0] CaseOffset = CodeBits'(32);

   // Tick counter ceiling
   localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

   typedef struct packed {
      logic                command;
      logic [CodeBits-1:0] key_code;
      logic                released;
   } req_type;

   typedef struct packed {
      logic [CodeBits-1:0] out_key;
      logic                shift_event;
      logic                is_press;
      logic                last;
   } rsp_type;

endpackage

### rtl/key_event_autorelease.sv
// Top level: key event autorelease with a three-entry result queue.
//
// Usage:
//   req channel carries one transaction per key event or timer tick
//   (command, key_code, released). rsp channel returns the resulting press
//   and release events, zero to three per transaction, the final one
//   marked by last. Shift events carry out_key 0.
//   csr port writes key_release_ticks, shift_release_ticks and
//   source_sends_release; write only while the block is idle.
// Timing:
//   State updates and all result events of a transaction are computed in
//   the accept cycle and loaded into a three-entry result queue; the first
//   event is valid on the next cycle. The queue drains one event a cycle
//   through the single rsp port while rsp_stall is low. A new transaction
//   is taken in the cycle the last queued event leaves.
// Reset: synchronous; registers return to 1, 1, 0, no key and no Shift
//   held, queue empty.
// Stall: rsp_stall holds the head event; req_stall stays high while any
//   event waits, except in the cycle the last one leaves.
module key_event_autorelease (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  kea_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output kea_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [kea_pkg::CsrIdxBits-1:0]       csr_index,
   input  logic [kea_pkg::CsrDataBits-1:0]      csr_wdata
);

   // Configuration registers
   logic [kea_pkg::LimitBits-1:0] key_lim_ff, key_lim_in;
   logic [kea_pkg::LimitBits-1:0] shift_lim_ff, shift_lim_in;
   logic                          src_rel_ff, src_rel_in;

   // Block state
   logic                          held_valid_ff, held_valid_in;
   logic [kea_pkg::CodeBits-1:0]  held_code_ff, held_code_in;
   logic [kea_pkg::TickBits-1:0]  held_ticks_ff, held_ticks_in;
   logic                          shift_held_ff, shift_held_in;
   logic [kea_pkg::TickBits-1:0]  shift_ticks_ff, shift_ticks_in;

   // Result queue
   kea_pkg::rsp_type              q_ff [3];
   kea_pkg::rsp_type              q_in [3];
   logic [1:0]                    cnt_ff, cnt_in;

   // Candidate events in output order
   kea_pkg::rsp_type              cand [3];
   logic [2:0]                    cand_v;
   kea_pkg::rsp_type              slot [3];
   logic [1:0]                    n_new;

   logic                          accept;
   logic                          pop;
   logic                          is_upper;
   logic                          is_lower;
   logic [kea_pkg::CodeBits-1:0]  code_lc;
   logic                          key_age_en;
   logic                          key_due;
   logic                          shift_age_en;
   logic                          shift_due;

   // Handshake
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop));
   assign accept    = req_valid && !req_stall;

   // Classify the key code
   always_comb begin
      is_upper = (req_data.key_code >= kea_pkg::CharUpperA) &&
                 (req_data.key_code <= kea_pkg::CharUpperZ);
      is_lower = (req_data.key_code >= kea_pkg::CharLowerA) &&
                 (req_data.key_code <= kea_pkg::CharLowerZ);
      code_lc  = is_upper ? (req_data.key_code + kea_pkg::CaseOffset) : req_data.key_code;
   end

   // Tick aging conditions
   always_comb begin
      key_age_en   = !src_rel_ff && (key_lim_ff != '0) && held_valid_ff;
      key_due      = key_age_en &&
                     (held_ticks_ff >= {1'b0, key_lim_ff});
      shift_age_en = (shift_lim_ff != '0) && shift_held_ff;
      shift_due    = shift_age_en &&
                     (shift_ticks_ff >= {1'b0, shift_lim_ff});
   end

   // Build candidate events
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cand[i] = '0;
      end
      cand_v = '0;
      if (req_data.command == kea_pkg::CmdKey) begin
         // Shift change implied by letter case
         cand[0].shift_event = 1'b1;
         cand[0].is_press    = is_upper;
         cand_v[0]           = (is_upper && !shift_held_ff) ||
                               (is_lower && shift_held_ff);
         // Release the previously held key
         cand[1].out_key     = held_code_ff;
         cand_v[1]           = !req_data.released && !src_rel_ff && held_valid_ff;
         // The event itself
         cand[2].out_key     = code_lc;
         cand[2].is_press    = !req_data.released;
         cand_v[2]           = 1'b1;
      end else begin
         cand[0].out_key     = held_code_ff;
         cand_v[0]           = key_due;
         cand[1].shift_event = 1'b1;
         cand_v[1]           = shift_due;
      end
   end

   // Pack valid candidates into queue slots and mark the last one
   always_comb begin
      slot[0] = cand_v[0] ? cand[0] : (cand_v[1] ? cand[1] : cand[2]);
      slot[1] = (cand_v[0] && cand_v[1]) ? cand[1] : cand[2];
      slot[2] = cand[2];
      n_new   = 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]);
      slot[0].last = (n_new == 2'd1);
      slot[1].last = (n_new == 2'd2);
      slot[2].last = (n_new == 2'd3);
   end

   // Next state of the block
   always_comb begin
      held_valid_in  = held_valid_ff;
      held_code_in   = held_code_ff;
      held_ticks_in  = held_ticks_ff;
      shift_held_in  = shift_held_ff;
      shift_ticks_in = shift_ticks_ff;
      if (accept) begin
         if (req_data.command == kea_pkg::CmdKey) begin
            if (is_upper) begin
               shift_held_in  = 1'b1;
               shift_ticks_in = '0;
            end else if (is_lower) begin
               shift_held_in  = 1'b0;
            end
            if (!req_data.released) begin
               held_valid_in = 1'b1;
               held_code_in  = code_lc;
               held_ticks_in = '0;
            end else begin
               held_valid_in = 1'b0;
            end
         end else begin
            if (key_age_en) begin
               if (held_ticks_ff != kea_pkg::TickMax) begin
                  held_ticks_in = held_ticks_ff + 1'b1;
               end
               if (key_due) begin
                  held_valid_in = 1'b0;
               end
            end
            if (shift_age_en) begin
               if (shift_ticks_ff != kea_pkg::TickMax) begin
                  shift_ticks_in = shift_ticks_ff + 1'b1;
               end
               if (shift_due) begin
                  shift_held_in = 1'b0;
               end
            end
         end
      end
   end

   // Load or advance the result queue
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         q_in   = slot;
         cnt_in = n_new;
      end else if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   // Configuration writes
   always_comb begin
      key_lim_in   = key_lim_ff;
      shift_lim_in = shift_lim_ff;
      src_rel_in   = src_rel_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            kea_pkg::RegKeyRelease:   key_lim_in   = csr_wdata;
            kea_pkg::RegShiftRelease: shift_lim_in = csr_wdata;
            kea_pkg::RegSourceRel:    src_rel_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_lim_ff     <= kea_pkg::LimitBits'(1);
         shift_lim_ff   <= kea_pkg::LimitBits'(1);
         src_rel_ff     <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_code_ff   <= '0;
         held_ticks_ff  <= '0;
         shift_held_ff  <= 1'b0;
         shift_ticks_ff <= '0;
         cnt_ff         <= 2'd0;
      end else begin
         key_lim_ff     <= key_lim_in;
         shift_lim_ff   <= shift_lim_in;
         src_rel_ff     <= src_rel_in;
         held_valid_ff  <= held_valid_in;
         held_code_ff   <= held_code_in;
         held_ticks_ff  <= held_ticks_in;
         shift_held_ff  <= shift_held_in;
         shift_ticks_ff <= shift_ticks_in;
         cnt_ff         <= cnt_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // The head carries last exactly when it is the only event left
   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (cnt_ff == 2'd1)))
      else $error("last flag does not match queue fill");

   // A transaction is never taken over more than one waiting event
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> (cnt_ff <= 2'd1))
      else $error("transaction accepted over a busy queue");

   // A key event always yields at least one result next cycle
   a_key_yields: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.command == kea_pkg::CmdKey)) |=> rsp_valid)
      else $error("key event produced no result");

   // Shift events carry a zero key code
   a_shift_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.shift_event) |-> (rsp_data.out_key == '0))
      else $error("shift event with nonzero key code");

endmodule

### tb/key_event_autorelease_test.sv
`timescale 1ns / 1ps
// Testbench: self-checking test of key_event_autorelease with a built-in key event predictor.
module key_event_autorelease_test;

   localparam int CycleLimit = 2000000;
   localparam int Predicted  = -1;
   localparam int NumRows    = 22;

   // One queued transaction, with its events typed in where they are obvious
   typedef struct packed {
      kea_pkg::req_type        item;
      bit                      typed;
      logic [1:0]              typed_count;
      kea_pkg::rsp_type [2:0]  typed_events;
   } stim_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   kea_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   kea_pkg::rsp_type                rsp_data;
   logic                            csr_wr_en = 1'b0;
   logic [kea_pkg::CsrIdxBits-1:0]  csr_index = '0;
   logic [kea_pkg::CsrDataBits-1:0] csr_wdata = '0;

   // Predictor state and its copy of the registers
   logic [kea_pkg::LimitBits-1:0]   key_timeout = 16'd1;
   logic [kea_pkg::LimitBits-1:0]   shift_timeout = 16'd1;
   logic                            source_releases = 1'b0;
   logic                            key_down = 1'b0;
   logic [kea_pkg::CodeBits-1:0]    key_down_code = '0;
   logic [kea_pkg::TickBits-1:0]    key_down_ticks = '0;
   logic                            shift_down = 1'b0;
   logic [kea_pkg::TickBits-1:0]    shift_down_ticks = '0;
   kea_pkg::rsp_type                caused_events [3];
   int                              caused_count;

   stim_type                        queued_items [$];
   kea_pkg::rsp_type                awaited_events [$];
   stim_type                        directed_table [NumRows];
   stim_type                        current_offer;
   kea_pkg::rsp_type                oldest_event;
   int                              error_count = 0;
   int                              cycle_count = 0;
   int                              hold_left = 0;
   bit                              hold_armed = 1'b0;
   bit                              calm = 1'b0;

   key_event_autorelease dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic kea_pkg::req_type make_req(logic cmd, logic [kea_pkg::CodeBits-1:0] code,
                                                 logic rel);
      kea_pkg::req_type r;
      r.command  = cmd;
      r.key_code = code;
      r.released = rel;
      return r;
   endfunction

   function automatic kea_pkg::rsp_type ev(int key, logic sh, logic press, logic fin);
      kea_pkg::rsp_type e;
      e.out_key     = key[kea_pkg::CodeBits-1:0];
      e.shift_event = sh;
      e.is_press    = press;
      e.last        = fin;
      return e;
   endfunction

   function automatic stim_type row(logic cmd, int code, logic rel, int count,
                                    kea_pkg::rsp_type e0 = '0, kea_pkg::rsp_type e1 = '0,
                                    kea_pkg::rsp_type e2 = '0);
      stim_type s;
      s.item         = make_req(cmd, code[kea_pkg::CodeBits-1:0], rel);
      s.typed        = (count >= 0);
      s.typed_count  = (count >= 0) ? count[1:0] : 2'd0;
      s.typed_events = {e2, e1, e0};
      return s;
   endfunction

   function automatic void offer_item(input kea_pkg::req_type r);
      stim_type s;
      s = '0;
      s.item = r;
      queued_items.push_back(s);
   endfunction

   function automatic void add_event(logic [kea_pkg::CodeBits-1:0] key, logic sh, logic press);
      caused_events[caused_count] = ev(int'(key), sh, press, 1'b0);
      caused_count++;
   endfunction

   function automatic logic [kea_pkg::TickBits-1:0] bump(logic [kea_pkg::TickBits-1:0] ticks);
      return (ticks == kea_pkg::TickMax) ? kea_pkg::TickMax : ticks + 1'b1;
   endfunction

   // Work out the press and release events one transaction causes
   function automatic void predict_key_events(input kea_pkg::req_type r);
      logic [kea_pkg::CodeBits-1:0] code;
      logic [kea_pkg::TickBits-1:0] prior;
      code = r.key_code;
      caused_count = 0;
      if (r.command == kea_pkg::CmdKey) begin
         // implied Shift comes first
         if (code >= kea_pkg::CharUpperA && code <= kea_pkg::CharUpperZ) begin
            code = code + kea_pkg::CaseOffset;
            if (!shift_down)
               add_event('0, 1'b1, 1'b1);
            shift_down = 1'b1;
            shift_down_ticks = '0;
         end else if (code >= kea_pkg::CharLowerA && code <= kea_pkg::CharLowerZ) begin
            if (shift_down)
               add_event('0, 1'b1, 1'b0);
            shift_down = 1'b0;
         end
         if (!r.released) begin
            if (!source_releases && key_down)
               add_event(key_down_code, 1'b0, 1'b0);
            add_event(code, 1'b0, 1'b1);
            key_down = 1'b1;
            key_down_code = code;
            key_down_ticks = '0;
         end else begin
            add_event(code, 1'b0, 1'b0);
            key_down = 1'b0;
         end
      end else begin
         // age the held key, then Shift, each against its own limit
         if (!source_releases && key_timeout != 0 && key_down) begin
            prior = key_down_ticks;
            key_down_ticks = bump(key_down_ticks);
            if (prior >= key_timeout) begin
               add_event(key_down_code, 1'b0, 1'b0);
               key_down = 1'b0;
            end
         end
         if (shift_timeout != 0 && shift_down) begin
            prior = shift_down_ticks;
            shift_down_ticks = bump(shift_down_ticks);
            if (prior >= shift_timeout) begin
               add_event('0, 1'b1, 1'b0);
               shift_down = 1'b0;
            end
         end
      end
      if (caused_count > 0)
         caused_events[caused_count-1].last = 1'b1;
   endfunction

   task automatic write_reg(input logic [kea_pkg::CsrIdxBits-1:0] idx,
                            input int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[kea_pkg::CsrDataBits-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      unique case (idx)
         kea_pkg::RegKeyRelease:   key_timeout = value[kea_pkg::LimitBits-1:0];
         kea_pkg::RegShiftRelease: shift_timeout = value[kea_pkg::LimitBits-1:0];
         kea_pkg::RegSourceRel:    source_releases = value[0];
         default: ;
      endcase
   endtask

   task automatic set_limits(input int unsigned key_ticks, input int unsigned shift_ticks,
                             input int unsigned src);
      write_reg(kea_pkg::RegKeyRelease, key_ticks);
      write_reg(kea_pkg::RegShiftRelease, shift_ticks);
      write_reg(kea_pkg::RegSourceRel, src);
   endtask

   // Wait until every transaction is taken and every event has come back
   task automatic drain();
      while (queued_items.size() != 0 || req_valid || awaited_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly well-formed press and release pairs, plus ticks and noise
   task automatic queue_random(input int total);
      int made;
      int pick;
      int gaps;
      logic [kea_pkg::CodeBits-1:0] letter;
      made = 0;
      while (made < total) begin
         pick = $urandom_range(99);
         letter = ($urandom_range(1) ? kea_pkg::CharUpperA : kea_pkg::CharLowerA) +
                  kea_pkg::CodeBits'($urandom_range(25));
         if (pick < 25) begin
            offer_item(make_req(kea_pkg::CmdTick, kea_pkg::CodeBits'($urandom), 1'($urandom)));
            made++;
         end else if (pick < 65) begin
            gaps = $urandom_range(3);
            offer_item(make_req(kea_pkg::CmdKey, letter, 1'b0));
            repeat (gaps) offer_item(make_req(kea_pkg::CmdTick, '0, 1'b0));
            offer_item(make_req(kea_pkg::CmdKey, letter, 1'b1));
            made += 2 + gaps;
         end else if (pick < 85) begin
            offer_item(make_req(kea_pkg::CmdKey, letter, 1'($urandom_range(3) == 0)));
            made++;
         end else begin
            offer_item(make_req(kea_pkg::CmdKey, kea_pkg::CodeBits'($urandom), 1'($urandom)));
            made++;
         end
      end
   endtask

   // Offer transactions; book the expected events when one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_key_events(current_offer.item);
            if (current_offer.typed) begin
               for (int i = 0; i < int'(current_offer.typed_count); i++)
                  awaited_events.push_back(current_offer.typed_events[i]);
            end else begin
               for (int i = 0; i < caused_count; i++)
                  awaited_events.push_back(caused_events[i]);
            end
         end
         if (queued_items.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
            current_offer = queued_items.pop_front();
            req_data <= current_offer.item;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check each event taken, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event, key %0d", rsp_data.out_key));
         end else begin
            oldest_event = awaited_events.pop_front();
            if (rsp_data.out_key != oldest_event.out_key)
               report_mismatch($sformatf("out_key %0d, want %0d",
                                         rsp_data.out_key, oldest_event.out_key));
            if (rsp_data.shift_event != oldest_event.shift_event)
               report_mismatch($sformatf("shift_event %0b, want %0b",
                                         rsp_data.shift_event, oldest_event.shift_event));
            if (rsp_data.is_press != oldest_event.is_press)
               report_mismatch($sformatf("is_press %0b, want %0b",
                                         rsp_data.is_press, oldest_event.is_press));
            if (rsp_data.last != oldest_event.last)
               report_mismatch($sformatf("last %0b, want %0b",
                                         rsp_data.last, oldest_event.last));
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed && rsp_valid) begin
         // hold off long enough for the block to fill and stall its input
         hold_armed = 1'b0;
         hold_left = 200;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 37);
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions at the reset settings: limits 1 and 1, no source releases
      directed_table = '{
         // command          code  released  events
         row(kea_pkg::CmdTick,    0, 1'b0, 0),
         row(kea_pkg::CmdKey,    65, 1'b0, 2, ev(0, 1'b1, 1'b1, 1'b0), ev(97, 1'b0, 1'b1, 1'b1)),
         row(kea_pkg::CmdTick,  511, 1'b1, Predicted),
         row(kea_pkg::CmdTick,    0, 1'b0, Predicted),
         row(kea_pkg::CmdKey,    90, 1'b0, Predicted),
         row(kea_pkg::CmdKey,    98, 1'b0, Predicted),
         row(kea_pkg::CmdKey,    98, 1'b1, 1, ev(98, 1'b0, 1'b0, 1'b1)),
         row(kea_pkg::CmdKey,   511, 1'b0, 1, ev(511, 1'b0, 1'b1, 1'b1)),
         row(kea_pkg::CmdKey,     0, 1'b0, 2, ev(511, 1'b0, 1'b0, 1'b0), ev(0, 1'b0, 1'b1, 1'b1)),
         row(kea_pkg::CmdKey,   300, 1'b1, Predicted),
         row(kea_pkg::CmdKey,    64, 1'b0, Predicted),
         row(kea_pkg::CmdKey,    91, 1'b0, Predicted),
         row(kea_pkg::CmdKey,    96, 1'b0, Predicted),
         row(kea_pkg::CmdKey,   123, 1'b0, Predicted),
         row(kea_pkg::CmdKey,   122, 1'b0, Predicted),
         row(kea_pkg::CmdKey,    65, 1'b1, Predicted),
         row(kea_pkg::CmdKey,    97, 1'b1, Predicted),
         row(kea_pkg::CmdKey,   321, 1'b0, Predicted),
         row(kea_pkg::CmdTick,    0, 1'b0, Predicted),
         row(kea_pkg::CmdTick,    0, 1'b0, Predicted),
         row(kea_pkg::CmdKey,   255, 1'b1, Predicted),
         row(kea_pkg::CmdTick,    0, 1'b0, Predicted)
      };
      foreach (directed_table[i])
         queued_items.push_back(directed_table[i]);
      drain();

      // Source sends releases, both timeouts off, no idling on either side
      calm = 1'b1;
      set_limits(0, 0, 1);
      queue_random(60);
      drain();
      calm = 1'b0;

      // Top limits: a shifted key stays held over a few ticks, then a lowercase release
      set_limits(65535, 65535, 0);
      offer_item(make_req(kea_pkg::CmdKey, kea_pkg::CharUpperA + kea_pkg::CodeBits'(16), 1'b0));
      repeat (6) offer_item(make_req(kea_pkg::CmdTick, '0, 1'b0));
      offer_item(make_req(kea_pkg::CmdKey, kea_pkg::CharLowerA + kea_pkg::CodeBits'(16), 1'b1));
      drain();

      // Separate key and Shift limits, with a long receiver hold-off
      set_limits(3, 2, 0);
      hold_armed = 1'b1;
      queue_random(120);
      drain();

      repeat (3) begin
         set_limits($urandom_range(1, 5), $urandom_range(0, 5), $urandom_range(1));
         queue_random(40);
         drain();
      end

      // Key timeout only
      set_limits(1, 0, 0);
      queue_random(40);
      drain();

      if (awaited_events.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", awaited_events.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### key_event_autorelease.f
rtl/kea_pkg.sv
rtl/key_event_autorelease.sv
tb/key_event_autorelease_test.sv
